>>> rtl/rff_pkg.sv
// Package for the range/flow frame parser: frame constants, parse phases,
// configuration register indexes and reset values. No dependencies.
package rff_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  localparam logic [7:0] SYNC_BYTE    = 8'hEF;
  localparam logic [7:0] RANGE_MSG_ID = 8'h51;

  // Header: device id, system id, message id, sequence, payload length
  localparam int unsigned HDR_LEN     = 5;
  localparam int unsigned HDR_MSG_IDX = 2;

  // Captured payload window: payload bytes 4..17
  localparam int unsigned CAP_FIRST = 4;
  localparam int unsigned CAP_LEN   = 14;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic        DECODE_EN_RST = 1'b0;
  localparam logic [15:0] RANGE_MIN_RST = 16'd1;
  localparam logic [15:0] RANGE_MAX_RST = 16'd6000;

  typedef enum logic [1:0] {
    PH_SYNC,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CKSUM
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECODE_EN = 2'd0,
    CFG_RANGE_MIN = 2'd1,
    CFG_RANGE_MAX = 2'd2
  } cfg_idx_e;

endpackage

>>> rtl/rff_if.sv
// Channel interfaces of the range/flow frame parser: byte input, result output
// and configuration write. Depends on rff_pkg.
interface rff_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rff_res_if;
  logic               valid;
  logic               ready;
  logic               checksum_ok;
  logic               measurement_updated;
  logic [31:0]        distance_mm;
  logic [7:0]         distance_strength;
  logic [7:0]         distance_precision;
  logic [7:0]         distance_status;
  logic signed [15:0] velocity_x;
  logic signed [15:0] velocity_y;
  logic [7:0]         flow_quality;
  logic [7:0]         flow_state;
  logic [15:0]        error_count;
  modport source (output valid, output checksum_ok, output measurement_updated,
                  output distance_mm, output distance_strength, output distance_precision,
                  output distance_status, output velocity_x, output velocity_y,
                  output flow_quality, output flow_state, output error_count,
                  input ready);
  modport sink   (input valid, input checksum_ok, input measurement_updated,
                  input distance_mm, input distance_strength, input distance_precision,
                  input distance_status, input velocity_x, input velocity_y,
                  input flow_quality, input flow_state, input error_count,
                  output ready);
endinterface

interface rff_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rff_pkg::CFG_IDX_W-1:0]  index;
  logic [rff_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/range_flow_frame_parser.sv
// The result of a frame is loaded into the output register as its checksum byte
// is accepted. Throughput: one byte per cycle, set by the parse/sum/latch logic
// that handles each byte in one pass; input stalls only while a result waits.
// Reset: hunting for sync, running sum 0xEF, latched fields and error count
// zero, decode disabled, range limits 1 and 6000 mm.
module range_flow_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = rff_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rff_byte_if.sink         rx_i,
  rff_res_if.source        res_o,
  rff_cfg_if.sink          cfg_i
);

  // Position counter must reach the largest payload length
  localparam int unsigned PW = $clog2(MAX_PAYLOAD + 1);

  // Configuration registers
  logic        decode_en_q;
  logic [15:0] range_min_q, range_max_q;

  // Parser state
  rff_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [PW-1:0]   size_q, size_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      msg_id_q, msg_id_d;
  logic [7:0]      cap_q [rff_pkg::CAP_LEN];
  logic [7:0]      cap_d [rff_pkg::CAP_LEN];

  // Latched measurement, visible on the result port directly
  logic [31:0] dist_q, dist_d;
  logic [7:0]  strength_q, strength_d;
  logic [7:0]  precision_q, precision_d;
  logic [7:0]  dstatus_q, dstatus_d;
  logic [15:0] vx_q, vx_d;
  logic [15:0] vy_q, vy_d;
  logic [7:0]  fquality_q, fquality_d;
  logic [7:0]  fstatus_q, fstatus_d;
  logic [15:0] err_q, err_d;

  // Output register flags
  logic out_valid_q, out_valid_d;
  logic out_ok_q, out_ok_d;
  logic out_upd_q, out_upd_d;

  logic          accept;
  logic [7:0]    c;
  logic [PW:0]   pos_inc;
  logic [31:0]   cap_dist;
  logic          ok, upd, dist_valid;

  // A new byte goes in whenever the result slot is free or being drained.
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign c          = rx_i.rx_byte;
  assign pos_inc    = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};

  // Little-endian distance from payload bytes 4..7
  assign cap_dist   = {cap_q[3], cap_q[2], cap_q[1], cap_q[0]};
  assign dist_valid = (cap_q[6] != 8'd0) && (cap_dist >= {16'd0, range_min_q})
                      && (cap_dist < {16'd0, range_max_q});
  assign ok         = (c == sum_q);
  assign upd        = ok && (msg_id_q == rff_pkg::RANGE_MSG_ID) && decode_en_q;

  // Configuration transactions are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_en_q <= rff_pkg::DECODE_EN_RST;
      range_min_q <= rff_pkg::RANGE_MIN_RST;
      range_max_q <= rff_pkg::RANGE_MAX_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rff_pkg::CFG_DECODE_EN: decode_en_q <= cfg_i.data[0];
        rff_pkg::CFG_RANGE_MIN: range_min_q <= cfg_i.data;
        rff_pkg::CFG_RANGE_MAX: range_max_q <= cfg_i.data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Next state: parse, sum, capture and latch in one pass per byte
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    size_d      = size_q;
    sum_d       = sum_q;
    msg_id_d    = msg_id_q;
    cap_d       = cap_q;
    dist_d      = dist_q;
    strength_d  = strength_q;
    precision_d = precision_q;
    dstatus_d   = dstatus_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    fquality_d  = fquality_q;
    fstatus_d   = fstatus_q;
    err_d       = err_q;
    out_ok_d    = out_ok_q;
    out_upd_d   = out_upd_q;
    out_valid_d = out_valid_q && !res_o.ready;

    if (accept) begin
      case (phase_q)
        rff_pkg::PH_SYNC: begin
          if (c == rff_pkg::SYNC_BYTE) begin
            phase_d = rff_pkg::PH_HEADER;
            pos_d   = '0;
            sum_d   = rff_pkg::SYNC_BYTE;
            for (int i = 0; i < rff_pkg::CAP_LEN; i++) begin
              cap_d[i] = 8'd0;
            end
          end
        end
        rff_pkg::PH_HEADER: begin
          sum_d = sum_q + c;
          if (pos_q == PW'(rff_pkg::HDR_MSG_IDX)) begin
            msg_id_d = c;
          end
          if (pos_q == PW'(rff_pkg::HDR_LEN - 1)) begin
            pos_d  = '0;
            size_d = c[PW-1:0];
            // oversized length drops the frame; zero length skips the payload
            if ({1'b0, c} > 9'(MAX_PAYLOAD)) begin
              phase_d = rff_pkg::PH_SYNC;
            end else if (c == 8'd0) begin
              phase_d = rff_pkg::PH_CKSUM;
            end else begin
              phase_d = rff_pkg::PH_PAYLOAD;
            end
          end else begin
            pos_d = pos_inc[PW-1:0];
          end
        end
        rff_pkg::PH_PAYLOAD: begin
          sum_d = sum_q + c;
          for (int i = 0; i < rff_pkg::CAP_LEN; i++) begin
            if (pos_q == PW'(rff_pkg::CAP_FIRST + i)) begin
              cap_d[i] = c;
            end
          end
          pos_d = pos_inc[PW-1:0];
          if (pos_inc == {1'b0, size_q}) begin
            phase_d = rff_pkg::PH_CKSUM;
          end
        end
        rff_pkg::PH_CKSUM: begin
          if (upd) begin
            dist_d      = dist_valid ? cap_dist : 32'hFFFF_FFFF;
            strength_d  = cap_q[4];
            precision_d = cap_q[5];
            dstatus_d   = cap_q[6];
            vx_d        = {cap_q[9], cap_q[8]};
            vy_d        = {cap_q[11], cap_q[10]};
            fquality_d  = cap_q[12];
            fstatus_d   = cap_q[13];
          end
          if (!ok) begin
            err_d = err_q + 16'd1;
          end
          phase_d     = rff_pkg::PH_SYNC;
          pos_d       = '0;
          out_ok_d    = ok;
          out_upd_d   = upd;
          out_valid_d = 1'b1;
        end
        default: begin
          phase_d = rff_pkg::PH_SYNC;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rff_pkg::PH_SYNC;
      pos_q       <= '0;
      size_q      <= '0;
      sum_q       <= rff_pkg::SYNC_BYTE;
      msg_id_q    <= 8'd0;
      for (int i = 0; i < rff_pkg::CAP_LEN; i++) begin
        cap_q[i] <= 8'd0;
      end
      dist_q      <= 32'd0;
      strength_q  <= 8'd0;
      precision_q <= 8'd0;
      dstatus_q   <= 8'd0;
      vx_q        <= 16'd0;
      vy_q        <= 16'd0;
      fquality_q  <= 8'd0;
      fstatus_q   <= 8'd0;
      err_q       <= 16'd0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_upd_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      size_q      <= size_d;
      sum_q       <= sum_d;
      msg_id_q    <= msg_id_d;
      cap_q       <= cap_d;
      dist_q      <= dist_d;
      strength_q  <= strength_d;
      precision_q <= precision_d;
      dstatus_q   <= dstatus_d;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      fquality_q  <= fquality_d;
      fstatus_q   <= fstatus_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      out_ok_q    <= out_ok_d;
      out_upd_q   <= out_upd_d;
    end
  end

  // Latched fields only change together with loading a result, so a held
  // result keeps its values while stalled.
  assign res_o.valid               = out_valid_q;
  assign res_o.checksum_ok         = out_ok_q;
  assign res_o.measurement_updated = out_upd_q;
  assign res_o.distance_mm         = dist_q;
  assign res_o.distance_strength   = strength_q;
  assign res_o.distance_precision  = precision_q;
  assign res_o.distance_status     = dstatus_q;
  assign res_o.velocity_x          = $signed(vx_q);
  assign res_o.velocity_y          = $signed(vy_q);
  assign res_o.flow_quality        = fquality_q;
  assign res_o.flow_state          = fstatus_q;
  assign res_o.error_count         = err_q;

endmodule

>>> test/tb_range_flow_frame_parser.sv
// Self-checking testbench for range_flow_frame_parser: directed frame table, then random
// frames, broken frames and line noise under random idling on the byte and result channels.
// Depends on rff_pkg and the channel interfaces in rff_if.sv.
module tb_range_flow_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import rff_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1100;
  localparam int unsigned STUCK_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 4;

  localparam logic [7:0]  NON_RANGE_MSG_ID = 8'h50;
  localparam logic [31:0] DIST_INVALID     = 32'hFFFF_FFFF;

  // Payload offsets of the fields carried by a range message
  localparam int unsigned DIST_OFS      = 4;
  localparam int unsigned STRENGTH_OFS  = 8;
  localparam int unsigned PRECISION_OFS = 9;
  localparam int unsigned STATUS_OFS    = 10;
  localparam int unsigned VX_OFS        = 12;
  localparam int unsigned VY_OFS        = 14;
  localparam int unsigned FQ_OFS        = 16;
  localparam int unsigned FS_OFS        = 17;

  typedef struct {
    logic               ok;
    logic               upd;
    logic [31:0]        range_mm;
    logic [7:0]         strength;
    logic [7:0]         precision;
    logic [7:0]         status;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [7:0]         flow_q;
    logic [7:0]         flow_st;
    logic [15:0]        errs;
  } frame_result_t;

  // One directed frame: settings to apply first, frame content, and - where it is
  // obvious - the report it must produce (typed = 1).
  typedef struct {
    logic        dec;
    logic [15:0] rmin;
    logic [15:0] rmax;
    logic [7:0]  msg;
    logic [7:0]  len;
    logic [31:0] range_mm;
    logic [7:0]  status;
    logic [7:0]  fill;
    logic [7:0]  bad;
    int          noise;
    bit          typed;
    logic        ok;
    logic        upd;
    logic [31:0] x_range;
    logic [15:0] x_errs;
  } frame_case_t;

  // dec rmin rmax msg len range status fill bad noise | typed ok upd range errs
  frame_case_t frame_cases [21] = '{
    // decode off after reset: fields stay at reset
    '{0, 1, 6000, RANGE_MSG_ID, 18, 1000, 1, 'h00, 0, 3, 1, 1, 0, 0, 0},
    '{1, 1, 6000, RANGE_MSG_ID, 18, 1000, 1, 'hFF, 0, 0, 1, 1, 1, 1000, 0},
    // bad sum holds the fields and counts one failure
    '{1, 1, 6000, RANGE_MSG_ID, 18, 2000, 1, 'h80, 'h01, 16, 1, 0, 0, 1000, 1},
    '{1, 1, 6000, RANGE_MSG_ID, 18, 1, 'h80, 'h7F, 0, 0, 1, 1, 1, 1, 1},
    '{1, 1, 6000, RANGE_MSG_ID, 18, 0, 'h01, 'h00, 0, 0, 1, 1, 1, DIST_INVALID, 1},
    '{1, 1, 6000, RANGE_MSG_ID, 18, 5999, 'hFF, 'h55, 0, 1, 1, 1, 1, 5999, 1},
    '{1, 1, 6000, RANGE_MSG_ID, 18, 6000, 'h01, 'hAA, 0, 0, 1, 1, 1, DIST_INVALID, 1},
    // zero status invalidates any distance
    '{1, 1, 6000, RANGE_MSG_ID, 18, 100, 0, 'h01, 0, 0, 1, 1, 1, DIST_INVALID, 1},
    '{1, 1, 6000, NON_RANGE_MSG_ID, 18, 100, 1, 'h02, 0, 0, 1, 1, 0, DIST_INVALID, 1},
    // zero length: checksum follows the header, capture reads as zero
    '{1, 1, 6000, RANGE_MSG_ID, 0, 100, 1, 'h00, 0, 0, 1, 1, 1, DIST_INVALID, 1},
    '{1, 1, 6000, RANGE_MSG_ID, 64, 'h1234, 2, 'hA5, 0, 0, 1, 1, 1, 'h1234, 1},
    // oversize lengths drop the frame without a report
    '{1, 1, 6000, RANGE_MSG_ID, 65, 100, 1, 'h00, 0, 0, 0, 0, 0, 0, 0},
    '{1, 1, 6000, RANGE_MSG_ID, 255, 100, 1, 'h00, 0, 2, 0, 0, 0, 0, 0},
    '{1, 0, 65535, RANGE_MSG_ID, 18, 0, 1, 'hC3, 0, 0, 1, 1, 1, 0, 1},
    '{1, 0, 65535, RANGE_MSG_ID, 18, 65534, 1, 'h3C, 0, 0, 1, 1, 1, 65534, 1},
    '{1, 0, 65535, RANGE_MSG_ID, 18, 'hFFFF_FFFF, 1, 'hFF, 0, 0, 1, 1, 1, DIST_INVALID, 1},
    '{1, 65535, 0, RANGE_MSG_ID, 18, 100, 1, 'h00, 0, 0, 1, 1, 1, DIST_INVALID, 1},
    '{1, 65535, 0, RANGE_MSG_ID, 5, 100, 1, 'h00, 'hFF, 0, 1, 0, 0, DIST_INVALID, 2},
    // short payload: status byte never arrives, so it reads as zero
    '{1, 65535, 0, RANGE_MSG_ID, 10, 100, 1, 'h11, 0, 0, 1, 1, 1, DIST_INVALID, 2},
    '{0, 1, 6000, RANGE_MSG_ID, 18, 1000, 1, 'h3C, 0, 2, 1, 1, 0, DIST_INVALID, 2},
    '{0, 1, 6000, NON_RANGE_MSG_ID, 0, 0, 0, 'h00, 'h80, 0, 1, 0, 0, DIST_INVALID, 3}
  };

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  rff_byte_if rx_if ();
  rff_res_if  res_if ();
  rff_cfg_if  cfg_if ();

  range_flow_frame_parser i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Parser mirror: settings, parse state and latched measurement
  // ---------------------------------------------------------------------------
  logic        cfg_dec;
  logic [15:0] cfg_rmin;
  logic [15:0] cfg_rmax;

  phase_e      ph;
  logic [7:0]  hdr [HDR_LEN];
  logic [6:0]  pos;
  logic [7:0]  plen;
  logic [7:0]  run_sum;
  logic [7:0]  cap_buf [CAP_LEN];
  frame_result_t held;

  frame_result_t due_reports [$];

  // Typed expectation for the next report of a directed row
  bit          pin_on;
  logic        pin_ok;
  logic        pin_upd;
  logic [31:0] pin_range;
  logic [15:0] pin_errs;

  int unsigned n_bytes;
  int unsigned n_frames;
  int unsigned n_checked;
  int unsigned n_writes;
  int unsigned n_errors;
  int unsigned stuck_cycles;
  int unsigned res_hold;
  bit          rx_calm;
  bit          res_calm;

  // Feeds one accepted byte to the mirror. Returns 1 when the byte closes a frame.
  function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r,
                                    output bit ignored);
    logic [31:0] range_raw;
    logic        ok;
    logic        upd;
    ignored = 1'b0;
    r = held;
    case (ph)
      PH_SYNC: begin
        ignored = (b != SYNC_BYTE);
        if (!ignored) begin
          ph = PH_HEADER;
          pos = '0;
          run_sum = SYNC_BYTE;
          foreach (cap_buf[i]) cap_buf[i] = '0;
        end
        return 1'b0;
      end
      PH_HEADER: begin
        hdr[pos] = b;
        run_sum += b;
        pos++;
        if (pos >= HDR_LEN) begin
          pos = '0;
          plen = hdr[HDR_LEN-1];
          if (plen > MAX_PAYLOAD_DEF) ph = PH_SYNC;
          else if (plen == 0) ph = PH_CKSUM;
          else ph = PH_PAYLOAD;
        end
        return 1'b0;
      end
      PH_PAYLOAD: begin
        if (pos >= CAP_FIRST && pos < CAP_FIRST + CAP_LEN) cap_buf[pos - CAP_FIRST] = b;
        run_sum += b;
        pos++;
        if (pos >= plen) ph = PH_CKSUM;
        return 1'b0;
      end
      PH_CKSUM: begin
        ok  = (b == run_sum);
        upd = ok && hdr[HDR_MSG_IDX] == RANGE_MSG_ID && cfg_dec;
        if (upd) begin
          range_raw = {cap_buf[DIST_OFS+3-CAP_FIRST], cap_buf[DIST_OFS+2-CAP_FIRST],
                       cap_buf[DIST_OFS+1-CAP_FIRST], cap_buf[DIST_OFS-CAP_FIRST]};
          held.status = cap_buf[STATUS_OFS-CAP_FIRST];
          if (held.status != 0 && range_raw >= {16'd0, cfg_rmin}
              && range_raw < {16'd0, cfg_rmax})
            held.range_mm = range_raw;
          else
            held.range_mm = DIST_INVALID;
          held.strength  = cap_buf[STRENGTH_OFS-CAP_FIRST];
          held.precision = cap_buf[PRECISION_OFS-CAP_FIRST];
          held.vel_x   = {cap_buf[VX_OFS+1-CAP_FIRST], cap_buf[VX_OFS-CAP_FIRST]};
          held.vel_y   = {cap_buf[VY_OFS+1-CAP_FIRST], cap_buf[VY_OFS-CAP_FIRST]};
          held.flow_q  = cap_buf[FQ_OFS-CAP_FIRST];
          held.flow_st = cap_buf[FS_OFS-CAP_FIRST];
        end
        if (!ok) held.errs++;
        ph = PH_SYNC;
        pos = '0;
        r = held;
        r.ok = ok;
        r.upd = upd;
        if (pin_on) begin
          r.ok = pin_ok;
          r.upd = pin_upd;
          r.range_mm = pin_range;
          r.errs = pin_errs;
          pin_on = 1'b0;
        end
        return 1'b1;
      end
      default: begin
        ph = PH_SYNC;
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: all inputs change on the falling edge
  // ---------------------------------------------------------------------------
  // Valid stays high from one byte to the next when there is no gap, so it is
  // never lowered and raised within the same step.
  task automatic send_byte(input logic [7:0] b);
    int            gap;
    frame_result_t r;
    bit            ign;
    gap = rx_calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    if (parse_byte(b, r, ign)) begin
      due_reports.push_back(r);
      n_frames++;
    end
    if (!ign) n_bytes++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_DECODE_EN: cfg_dec  = val[0];
      CFG_RANGE_MIN: cfg_rmin = val;
      CFG_RANGE_MAX: cfg_rmax = val;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop the byte stream and let every outstanding report come back. The extra
  // cycles cover bytes that end a frame without a report (oversize length).
  task automatic settle();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Optional junk before the sync byte, then sync, header, payload and checksum (header only
  // for an oversize length). A nonzero cut keeps only the first cut bytes (broken frame).
  task automatic send_frame(input logic [7:0] msg_id, input logic [7:0] len,
                            input logic [31:0] range_mm, input logic [7:0] status,
                            input logic [7:0] fill, input bit scramble,
                            input logic [7:0] bad, input int noise, input int cut);
    logic [7:0] seq [$];
    logic [7:0] head [HDR_LEN];
    logic [7:0] b;
    logic [7:0] csum;
    int         k;
    for (k = 0; k < noise; k++) begin
      b = scramble ? 8'($urandom) : 8'(k * 8'h11);
      if (b == SYNC_BYTE) b ^= 8'h01;
      seq.push_back(b);
    end
    seq.push_back(SYNC_BYTE);
    head = '{8'($urandom), 8'($urandom), msg_id, 8'($urandom), len};
    csum = SYNC_BYTE;
    for (k = 0; k < HDR_LEN; k++) begin
      csum += head[k];
      seq.push_back(head[k]);
    end
    if (len <= MAX_PAYLOAD_DEF) begin
      for (k = 0; k < len; k++) begin
        if (k >= DIST_OFS && k < DIST_OFS + 4) b = range_mm[8*(k-DIST_OFS) +: 8];
        else if (k == STATUS_OFS) b = status;
        else b = scramble ? 8'($urandom) : fill;
        csum += b;
        seq.push_back(b);
      end
      seq.push_back(csum ^ bad);
    end
    if (cut > 0 && cut < seq.size()) seq = seq[0:cut-1];
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Report side: random back-pressure, field-by-field compare
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (res_hold > 0) begin
      res_if.ready <= 1'b0;
      res_hold = res_hold - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : report_check
    frame_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      n_checked++;
      res_hold = res_calm ? 0 : $urandom_range(0, 12);
      if (due_reports.size() == 0) begin
        $error("frame report with none outstanding");
        n_errors++;
      end else begin
        want = due_reports.pop_front();
        check_field("checksum_ok", 32'(want.ok), 32'(res_if.checksum_ok));
        check_field("measurement_updated", 32'(want.upd),
                    32'(res_if.measurement_updated));
        check_field("distance_mm", want.range_mm, res_if.distance_mm);
        check_field("distance_strength", 32'(want.strength),
                    32'(res_if.distance_strength));
        check_field("distance_precision", 32'(want.precision),
                    32'(res_if.distance_precision));
        check_field("distance_status", 32'(want.status), 32'(res_if.distance_status));
        check_field("velocity_x", 32'(want.vel_x), 32'(res_if.velocity_x));
        check_field("velocity_y", 32'(want.vel_y), 32'(res_if.velocity_y));
        check_field("flow_quality", 32'(want.flow_q), 32'(res_if.flow_quality));
        check_field("flow_state", 32'(want.flow_st), 32'(res_if.flow_state));
        check_field("error_count", 32'(want.errs), 32'(res_if.error_count));
      end
    end
  end

  // Watchdog: cycles in a row with no transaction on any channel
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[range_flow_frame_parser] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          kind;
    int          noise;
    int unsigned phase_end;
    logic [7:0]  msg;
    logic [7:0]  len;
    logic [31:0] range_mm;
    logic [7:0]  status;
    logic [7:0]  bad;
    logic [15:0] lo;
    logic [15:0] hi;

    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_DECODE_EN;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;
    rst_n         = 1'b0;

    // Mirror starts from the reset state of the block
    cfg_dec  = DECODE_EN_RST;
    cfg_rmin = RANGE_MIN_RST;
    cfg_rmax = RANGE_MAX_RST;
    ph       = PH_SYNC;
    pos      = '0;
    plen     = '0;
    run_sum  = SYNC_BYTE;
    foreach (hdr[i]) hdr[i] = '0;
    foreach (cap_buf[i]) cap_buf[i] = '0;
    held     = '{default: '0};
    pin_on   = 1'b0;
    res_hold = 0;
    rx_calm  = 1'b0;
    res_calm = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table; settings change only with the parser drained
    foreach (frame_cases[i]) begin
      if (frame_cases[i].dec != cfg_dec || frame_cases[i].rmin != cfg_rmin
          || frame_cases[i].rmax != cfg_rmax) begin
        settle();
        if (frame_cases[i].dec != cfg_dec)
          write_reg(CFG_DECODE_EN, {15'd0, frame_cases[i].dec});
        if (frame_cases[i].rmin != cfg_rmin) write_reg(CFG_RANGE_MIN, frame_cases[i].rmin);
        if (frame_cases[i].rmax != cfg_rmax) write_reg(CFG_RANGE_MAX, frame_cases[i].rmax);
      end
      rx_calm   = (i % 3 == 0);
      res_calm  = (i % 4 == 0);
      pin_on    = frame_cases[i].typed;
      pin_ok    = frame_cases[i].ok;
      pin_upd   = frame_cases[i].upd;
      pin_range = frame_cases[i].x_range;
      pin_errs  = frame_cases[i].x_errs;
      send_frame(frame_cases[i].msg, frame_cases[i].len, frame_cases[i].range_mm,
                 frame_cases[i].status, frame_cases[i].fill, 1'b0, frame_cases[i].bad,
                 frame_cases[i].noise, 0);
    end

    // Random phases: new settings, then mostly well-formed frames with random
    // content, some broken frames and raw line noise
    while (n_bytes < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 3))
        0: lo = 16'd0;
        1: lo = RANGE_MIN_RST;
        2: lo = 16'hFFFF;
        default: lo = 16'($urandom_range(0, 3000));
      endcase
      case ($urandom_range(0, 3))
        0: hi = 16'd0;
        1: hi = 16'hFFFF;
        2: hi = RANGE_MAX_RST;
        default: hi = 16'($urandom_range(65535, lo));
      endcase
      write_reg(CFG_DECODE_EN, {15'd0, ($urandom_range(0, 3) != 0)});
      write_reg(CFG_RANGE_MIN, lo);
      write_reg(CFG_RANGE_MAX, hi);
      rx_calm  = ($urandom_range(0, 3) == 0);
      res_calm = ($urandom_range(0, 3) == 0);
      phase_end = n_bytes + 150;

      while (n_bytes < phase_end && n_bytes < ITEM_TARGET) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          // raw noise, sync bytes included: may open or corrupt a frame
          repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
        end else begin
          msg = ($urandom_range(0, 3) != 0) ? RANGE_MSG_ID : 8'($urandom);
          case ($urandom_range(0, 9))
            0: len = 8'($urandom_range(0, 17));
            1: len = 8'($urandom_range(25, MAX_PAYLOAD_DEF));
            2: len = 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255));
            default: len = 8'($urandom_range(18, 24));
          endcase
          // distances around the current limits, plus wide random values
          case ($urandom_range(0, 5))
            0: range_mm = {16'd0, cfg_rmin};
            1: range_mm = {16'd0, cfg_rmin} - 1;
            2: range_mm = {16'd0, cfg_rmax};
            3: range_mm = {16'd0, cfg_rmax} - 1;
            4: range_mm = $urandom_range(0, 65535);
            default: range_mm = $urandom;
          endcase
          status = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
          bad    = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
          noise  = $urandom_range(0, 3);
          send_frame(msg, len, range_mm, status, 8'd0, 1'b1, bad, noise,
                     (kind == 1) ? $urandom_range(noise + 1, noise + 20) : 0);
        end
      end
    end

    settle();
    $display("Covered %0d parsed bytes, %0d frame reports and %0d register writes.",
             n_bytes, n_checked, n_writes);
    if (n_errors == 0)
      $display("[range_flow_frame_parser] OK");
    else
      $display("[range_flow_frame_parser] ERROR");
    $finish;
  end

endmodule

>>> range_flow_frame_parser.f
rtl/rff_pkg.sv
rtl/rff_if.sv
rtl/range_flow_frame_parser.sv
test/tb_range_flow_frame_parser.sv
